@@ rtl/lbh_pkg.sv @@
// Shared types, constants and the mix round function for the byte hash unit.
// No dependencies.
`default_nettype none

package lbh_pkg;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;
    localparam int BLOCK_BYTES = 12;
    localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
    localparam int MIX_LINES = 9;
    localparam int STEP_W = $clog2(MIX_LINES);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_LINES - 1);

    typedef logic [BLOCK_BYTES-1:0][7:0] byte_buf_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    // one queued unit of work for the mixing engine
    typedef struct packed {
        abc_t        words;      // block words, or tail words when has_block is 0
        logic        has_block;
        logic        final_mix;
        logic        first;      // reload state from golden value and seed
        logic [31:0] seed;
        logic [31:0] length;
    } job_t;

    function automatic abc_t mix_line(input logic [STEP_W-1:0] step, input abc_t v);
        abc_t r;
        r = v;
        unique case (step)
            4'd0: r.a = (v.a - v.b - v.c) ^ (v.c >> 13);
            4'd1: r.b = (v.b - v.c - v.a) ^ (v.a << 8);
            4'd2: r.c = (v.c - v.a - v.b) ^ (v.b >> 13);
            4'd3: r.a = (v.a - v.b - v.c) ^ (v.c >> 12);
            4'd4: r.b = (v.b - v.c - v.a) ^ (v.a << 16);
            4'd5: r.c = (v.c - v.a - v.b) ^ (v.b >> 5);
            4'd6: r.a = (v.a - v.b - v.c) ^ (v.c >> 3);
            4'd7: r.b = (v.b - v.c - v.a) ^ (v.a << 10);
            4'd8: r.c = (v.c - v.a - v.b) ^ (v.b >> 15);
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lookup2_byte_hash_unit.sv @@
// Top level of the streaming lookup2 byte hash unit.
// Depends on lbh_pkg, lbh_front, lbh_queue, lbh_back.
//
// Usage:
//   Key channel (key_valid/key_stall): one item per transfer carrying data_byte,
//   has_byte and last. A key is a run of items ending in an item with last set;
//   an item with last set and no byte ends an empty key.
//   Hash channel (hash_valid/hash_stall): one transfer of hash per key.
//   Config channel (cfg_valid/cfg_ready): writes the seed init_value; always
//   ready. The seed is sampled on the first item of each key.
// Throughput: one byte per cycle while key_stall is low. Each completed 12-byte
//   block costs the mixing engine one add and nine mix lines, so long keys
//   stream at full rate. Each key end costs one more add and nine mix lines (and
//   a length add and nine more mix lines when the last byte also completes a
//   block), so short keys are bound by the engine rather than the byte rate.
// Reset: clears the seed to zero, closes any open key, empties the job queue
//   and drops any pending hash.
// Stall: a stalled hash holds; the engine then waits at the end of its next
//   final mix, the two-entry queue fills and key_stall is raised.
`default_nettype none

module lookup2_byte_hash_unit
    import lbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_valid,
    output logic             key_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    output logic             hash_valid,
    input  wire logic        hash_stall,
    output logic [31:0]      hash,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] init_value
);

    logic [31:0] init_value_reg, init_value_next;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    job_t        push_job;
    job_t        pop_job;

    always_comb
    begin
        cfg_ready = 1'b1;
        key_stall = q_full;
        accept    = key_valid && !q_full;
        init_value_next = (cfg_valid && cfg_ready) ? init_value : init_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_value_reg <= '0;
        else
            init_value_reg <= init_value_next;
    end

    lbh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .init_value (init_value_reg),
        .push       (push),
        .job        (push_job)
    );

    lbh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    lbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (pop_job),
        .pop        (pop),
        .hash       (hash),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall)
    );

endmodule

`default_nettype wire

@@ rtl/lbh_front.sv @@
// Front end: takes key bytes, packs 12-byte blocks and tails, counts length.
// Depends on lbh_pkg.
`default_nettype none

module lbh_front
    import lbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    input  wire logic [31:0] init_value,
    output logic             push,
    output job_t             job
);

    logic             key_open_reg, key_open_next;
    logic             first_reg, first_next;
    logic [31:0]      seed_reg, seed_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]      len_reg, len_next;
    byte_buf_t        buf_reg, buf_next;

    logic             first_eff;
    logic [31:0]      seed_eff;
    logic [FILL_W-1:0] fill_eff, fill_w;
    logic [31:0]      len_eff, len_w;
    byte_buf_t        buf_eff, buf_w;
    logic             blk;

    always_comb
    begin
        first_eff = key_open_reg ? first_reg : 1'b1;
        seed_eff  = key_open_reg ? seed_reg  : init_value;
        fill_eff  = key_open_reg ? fill_reg  : '0;
        len_eff   = key_open_reg ? len_reg   : '0;
        buf_eff   = key_open_reg ? buf_reg   : '0;

        buf_w  = buf_eff;
        fill_w = fill_eff;
        len_w  = len_eff;
        if (has_byte)
        begin
            buf_w[fill_eff[FILL_W-1:0]] = data_byte;
            fill_w = fill_eff + 1'b1;
            len_w  = len_eff + 32'd1;
        end
        blk = has_byte && (fill_w == FILL_W'(BLOCK_BYTES));

        push = accept && (blk || last);

        job.has_block = blk;
        job.final_mix = last;
        job.first     = first_eff;
        job.seed      = seed_eff;
        job.length    = len_w;
        job.words.a   = buf_w[3:0];
        job.words.b   = buf_w[7:4];
        if (blk)
            job.words.c = buf_w[11:8];
        else
            job.words.c = {buf_w[10:8], 8'h00};

        key_open_next = key_open_reg;
        first_next    = first_reg;
        seed_next     = seed_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        buf_next      = buf_reg;
        if (accept)
        begin
            key_open_next = !last;
            first_next    = first_eff && !push;
            seed_next     = seed_eff;
            fill_next     = blk ? '0 : fill_w;
            len_next      = len_w;
            buf_next      = blk ? '0 : buf_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_open_reg <= 1'b0;
            first_reg    <= 1'b1;
            fill_reg     <= '0;
            len_reg      <= '0;
        end
        else
        begin
            key_open_reg <= key_open_next;
            first_reg    <= first_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        buf_reg  <= buf_next;
    end

endmodule

`default_nettype wire

@@ rtl/lbh_queue.sv @@
// Two-entry job queue between front end and mixing engine.
// Depends on lbh_pkg.
`default_nettype none

module lbh_queue
    import lbh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      full,
    output logic      empty
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        full  = (count_reg == 2'd2);
        empty = (count_reg == 2'd0);
        pop_job = mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

@@ rtl/lbh_back.sv @@
// Mixing engine: adds queued words into a/b/c, runs the mix one line per cycle
// unless a stalled output holds a final mix; holds the finished hash in an output register. Depends on lbh_pkg.
`default_nettype none

module lbh_back
    import lbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  job_t             q_job,
    output logic             pop,
    output logic [31:0]      hash,
    output logic             hash_valid,
    input  wire logic        hash_stall
);

    typedef enum logic [1:0] {S_IDLE, S_MIX, S_FIN} state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_final_reg, phase_final_next;
    logic              pend_final_reg, pend_final_next;
    logic [31:0]       len_reg, len_next;
    abc_t              abc_reg, abc_next;
    logic [31:0]       hash_reg, hash_next;
    logic              hash_valid_reg, hash_valid_next;

    abc_t              base;
    abc_t              mixed;
    logic              out_free;

    always_comb
    begin
        pop      = (state_reg == S_IDLE) && !q_empty;
        mixed    = mix_line(step_reg, abc_reg);
        out_free = !hash_valid_reg || !hash_stall;
        if (q_job.first)
            base = '{a: GOLDEN, b: GOLDEN, c: q_job.seed};
        else
            base = abc_reg;

        state_next       = state_reg;
        step_next        = step_reg;
        phase_final_next = phase_final_reg;
        pend_final_next  = pend_final_reg;
        len_next         = len_reg;
        abc_next         = abc_reg;
        hash_next        = hash_reg;
        hash_valid_next  = hash_valid_reg && hash_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    abc_next.a       = base.a + q_job.words.a;
                    abc_next.b       = base.b + q_job.words.b;
                    abc_next.c       = base.c + q_job.words.c
                                     + (q_job.has_block ? 32'd0 : q_job.length);
                    phase_final_next = !q_job.has_block;
                    pend_final_next  = q_job.has_block && q_job.final_mix;
                    len_next         = q_job.length;
                    step_next        = '0;
                    state_next       = S_MIX;
                end
            end
            S_MIX:
            begin
                if (step_reg != LAST_STEP)
                begin
                    abc_next  = mixed;
                    step_next = step_reg + 1'b1;
                end
                else if (phase_final_reg)
                begin
                    if (out_free)
                    begin
                        abc_next        = mixed;
                        hash_next       = mixed.c;
                        hash_valid_next = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    abc_next   = mixed;
                    state_next = pend_final_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                abc_next.c       = abc_reg.c + len_reg;
                phase_final_next = 1'b1;
                pend_final_next  = 1'b0;
                step_next        = '0;
                state_next       = S_MIX;
            end
            default: state_next = S_IDLE;
        endcase

        hash       = hash_reg;
        hash_valid = hash_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            phase_final_reg <= 1'b0;
            pend_final_reg  <= 1'b0;
            hash_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            phase_final_reg <= phase_final_next;
            pend_final_reg  <= pend_final_next;
            hash_valid_reg  <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        abc_reg  <= abc_next;
        hash_reg <= hash_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for lookup2_byte_hash_unit: streams byte keys, predicts each hash.
// It uses a built-in lookup2 predictor, random idling on the key channel and random stalls on the hash channel.
// Depends on lbh_pkg and lookup2_byte_hash_unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbh_pkg::GOLDEN;
    import lbh_pkg::BLOCK_BYTES;

    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        key_valid;
    logic        key_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        hash_valid;
    logic        hash_stall;
    logic [31:0] hash;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] init_value;

    lookup2_byte_hash_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash       (hash),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .init_value (init_value)
    );

    // predictor state
    logic [31:0] seed_shadow;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] key_c;
    logic [7:0]  key_bytes [BLOCK_BYTES];
    int unsigned key_fill;
    logic [31:0] key_len;
    bit          key_open;

    logic [31:0] hash_expected_q [$];
    logic [31:0] expected_hash;

    int tx_gap_max;
    int rx_hold_max;
    int hold_cycles;
    int mismatch_count;
    int hashes_checked;
    int items_sent;
    int keys_ended;
    int seed_writes;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d hashes still outstanding", hash_expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                                        inout logic [31:0] c);
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
    endfunction

    function automatic void predict_key_item(logic [7:0] d, logic hb, logic lst);
        int unsigned i;
        if (!key_open)
        begin
            key_a = GOLDEN;
            key_b = GOLDEN;
            key_c = seed_shadow;
            key_fill = 0;
            key_len = '0;
            foreach (key_bytes[j])
                key_bytes[j] = 8'h00;
            key_open = 1'b1;
        end
        if (hb)
        begin
            key_bytes[key_fill] = d;
            key_fill++;
            key_len++;
            if (key_fill == BLOCK_BYTES)
            begin
                key_a += {key_bytes[3], key_bytes[2], key_bytes[1], key_bytes[0]};
                key_b += {key_bytes[7], key_bytes[6], key_bytes[5], key_bytes[4]};
                key_c += {key_bytes[11], key_bytes[10], key_bytes[9], key_bytes[8]};
                lookup2_mix(key_a, key_b, key_c);
                key_fill = 0;
            end
        end
        if (lst)
        begin
            key_c += key_len;
            for (i = 0; i < key_fill; i++)
            begin
                if (i < 4)
                    key_a += 32'(key_bytes[i]) << (8 * i);
                else if (i < 8)
                    key_b += 32'(key_bytes[i]) << (8 * (i - 4));
                else
                    key_c += 32'(key_bytes[i]) << (8 * (i - 8) + 8);
            end
            lookup2_mix(key_a, key_b, key_c);
            hash_expected_q.push_back(key_c);
            key_open = 1'b0;
            keys_ended++;
        end
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d at %0t: %s expected %08h got %08h",
                     mismatch_count, $realtime, what, exp_v, got_v);
    endfunction

    // hash channel: random stall per transfer, check against oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_cycles = 0;
            hash_stall <= 1'b0;
        end
        else
        begin
            if (hash_valid && !hash_stall)
            begin
                if (hash_expected_q.size() == 0)
                    note_mismatch("hash with none outstanding", 32'h0, hash);
                else
                begin
                    expected_hash = hash_expected_q.pop_front();
                    hashes_checked++;
                    if (hash !== expected_hash)
                        note_mismatch("hash", expected_hash, hash);
                end
                hold_cycles = $urandom_range(0, rx_hold_max);
            end
            else if (hold_cycles != 0)
                hold_cycles--;
            hash_stall <= (hold_cycles != 0);
        end
    end

    // one key-channel transfer; valid stays high afterwards until the next call decides
    task automatic send_key_item(input logic [7:0] d, input logic hb, input logic lst);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_valid <= 1'b1;
        data_byte <= d;
        has_byte <= hb;
        last <= lst;
        do
            @(posedge clk);
        while (key_stall);
        predict_key_item(d, hb, lst);
        items_sent++;
    endtask

    task automatic drain_results();
        key_valid <= 1'b0;
        do
            @(posedge clk);
        while (hash_expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        init_value <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_shadow = v;
        seed_writes++;
    endtask

    task automatic test_empty_key();
        tx_gap_max = 0;
        rx_hold_max = 0;
        send_key_item(8'hA5, 1'b0, 1'b1);
        send_key_item(8'hFF, 1'b0, 1'b0);
        send_key_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_seed_extremes();
        tx_gap_max = 15;
        rx_hold_max = 15;
        write_seed(32'hFFFF_FFFF);
        send_key_item(8'hFF, 1'b1, 1'b1);
        write_seed(32'h0000_0000);
        send_key_item(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_full_block_end();
        int i;
        tx_gap_max = 0;
        rx_hold_max = 15;
        for (i = 0; i < BLOCK_BYTES; i++)
            send_key_item((i % 2) ? 8'h00 : 8'hFF, 1'b1, i == BLOCK_BYTES - 1);
    endtask

    // new seed must only apply from the next key start, including one opened by an idle item
    task automatic test_seed_mid_key();
        tx_gap_max = 15;
        rx_hold_max = 0;
        send_key_item(8'h5A, 1'b1, 1'b0);
        write_seed(32'h1234_5678);
        send_key_item(8'hA5, 1'b1, 1'b0);
        send_key_item(8'h3C, 1'b0, 1'b1);
        send_key_item(8'h00, 1'b0, 1'b0);
        write_seed(32'h8765_4321);
        send_key_item(8'hC3, 1'b1, 1'b1);
    endtask

    task automatic test_random_keys();
        int counted;
        int pick;
        int key_length;
        int i;
        bit end_marker;
        counted = 0;
        while (counted < 600)
        begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            rx_hold_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                key_length = 0;
            else if (pick < 70)
                key_length = $urandom_range(1, 14);
            else if (pick < 85)
                key_length = BLOCK_BYTES * $urandom_range(1, 3);
            else
                key_length = $urandom_range(15, 60);
            end_marker = (key_length == 0) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < key_length; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_key_item(8'($urandom), 1'b0, 1'b0);
                send_key_item(8'($urandom), 1'b1, (i == key_length - 1) && !end_marker);
                counted++;
            end
            if (end_marker)
            begin
                send_key_item(8'($urandom), 1'b0, 1'b1);
                counted++;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                pick = $urandom_range(0, 3);
                write_seed(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : 32'($urandom));
            end
            else if ($urandom_range(0, 15) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        key_valid = 1'b0;
        data_byte = 8'h00;
        has_byte = 1'b0;
        last = 1'b0;
        cfg_valid = 1'b0;
        init_value = 32'h0;
        seed_shadow = 32'h0;
        key_open = 1'b0;
        key_fill = 0;
        key_len = '0;
        tx_gap_max = 0;
        rx_hold_max = 0;
        mismatch_count = 0;
        hashes_checked = 0;
        items_sent = 0;
        keys_ended = 0;
        seed_writes = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_key();
        test_seed_extremes();
        test_full_block_end();
        test_seed_mid_key();
        test_random_keys();
        drain_results();

        $display("key channel: %0d transfers, %0d keys ended, %0d seed writes",
                 items_sent, keys_ended, seed_writes);
        $display("hash channel: %0d transfers checked, %0d mismatches, %0d outstanding",
                 hashes_checked, mismatch_count, hash_expected_q.size());
        if (mismatch_count == 0 && hash_expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
